### rtl/core/ostt_pkg.sv
// Package for the one-shot timer table: opcodes, result kinds, widths
// and the queue entry type. No dependencies.
`timescale 1ns / 1ps
package ostt_pkg;
   localparam int SLOTS_DEF = 16;
   localparam int TAG_BITS_DEF = 16;
   localparam int ID_W = 32;
   localparam int TAG_W = 16;
   localparam int MAX_RESULTS = 16;
   localparam int Q_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP = 2'd1,
      OP_TICK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ID = 2'd0,
      KIND_EXPIRED = 2'd1,
      KIND_REJECTED = 2'd2,
      KIND_SPARE = 2'd3
   } kind_type;

   typedef struct packed {
      op_type op;
      logic [ID_W-1:0] duration;
      logic [ID_W-1:0] target_id;
      logic [TAG_W-1:0] tag;
   } cmd_type;
endpackage

### rtl/core/one_shot_timer_table_top.sv
// Top level of the one-shot timer table: request front end, command
// queue and timer back end. Depends on ostt_pkg, ostt_front, ostt_back.
`timescale 1ns / 1ps
// Start and stop are executed in the idle state of the back end. The request
// side keeps a two-entry queue, which registers the commands, so they stream
// at one item per cycle while no tick is busy and the result side does not
// stall. A tick scans the SLOTS timers one per cycle to find the smallest due
// id, and scans anew after each expiry. It holds the back end until the due
// timers, up to MAX_RESULTS, are delivered, and longer when the result side
// stalls. Each expiry is delivered as one result; the final one has tlast set.
module one_shot_timer_table_top #(
   parameter int SLOTS = ostt_pkg::SLOTS_DEF,
   parameter int TAG_BITS = ostt_pkg::TAG_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,  // duration, target_id, user_tag
   input  logic [1:0]   req_tuser,  // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // timer_id, tag_out
   output logic [1:0]   rsp_tuser,  // kind
   output logic         rsp_tlast
);
   import ostt_pkg::*;
   logic cmd_valid, cmd_ready;
   cmd_type cmd;

   ostt_front #(.TAG_BITS(TAG_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(req_tuser), .in_duration(req_tdata[31:0]),
      .in_target_id(req_tdata[63:32]), .in_tag(req_tdata[79:64]),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
   );

   ostt_back #(.SLOTS(SLOTS)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_kind(rsp_tuser), .out_id(rsp_tdata[31:0]),
      .out_tag(rsp_tdata[47:32]), .out_last(rsp_tlast)
   );
endmodule

### rtl/core/ostt_front.sv
// Front end: accepts request items, drops unused opcodes, masks the tag
// and queues commands for the back end. Depends on ostt_pkg.
`timescale 1ns / 1ps
module ostt_front #(
   parameter int TAG_BITS = ostt_pkg::TAG_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_op,
   input  logic [31:0]       in_duration,
   input  logic [31:0]       in_target_id,
   input  logic [15:0]       in_tag,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output ostt_pkg::cmd_type cmd
);
   import ostt_pkg::*;
   localparam int KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam logic [TAG_W-1:0] TAG_MASK = (KEEP >= TAG_W) ? '1 :
      TAG_W'((1 << KEEP) - 1);

   cmd_type q_ff [Q_DEPTH];
   logic q_rd_ff, q_rd_in, q_wr_ff, q_wr_in;
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic push, pop;
   cmd_type c;

   assign in_ready = (q_cnt_ff != 2'(Q_DEPTH));
   assign push = in_valid && in_ready && (op_type'(in_op) != OP_NONE);
   assign cmd_valid = (q_cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[q_rd_ff];

   always_comb begin
      c.op = op_type'(in_op);
      c.duration = in_duration;
      c.target_id = in_target_id;
      c.tag = in_tag & TAG_MASK;
      q_wr_in = push ? ~q_wr_ff : q_wr_ff;
      q_rd_in = pop ? ~q_rd_ff : q_rd_ff;
      q_cnt_in = q_cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[q_wr_ff] <= c;
      if (reset) begin
         q_rd_ff <= 1'b0;
         q_wr_ff <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         q_rd_ff <= q_rd_in;
         q_wr_ff <= q_wr_in;
         q_cnt_ff <= q_cnt_in;
      end
   end
endmodule

### rtl/core/ostt_back.sv
// Back end: timer slot table, time and id counters, start/stop/tick
// execution and the result register. Depends on ostt_pkg.
`timescale 1ns / 1ps
module ostt_back #(
   parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  ostt_pkg::cmd_type cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [1:0]        out_kind,
   output logic [31:0]       out_id,
   output logic [15:0]       out_tag,
   output logic              out_last
);
   import ostt_pkg::*;
   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type st_ff, st_in;
   logic [ID_W-1:0] time_ff, time_in, idc_ff, idc_in;
   logic [SLOTS-1:0] valid_ff, valid_in, due_ff, due_in;
   logic [ID_W-1:0] sid_ff [SLOTS];
   logic [ID_W-1:0] sst_ff [SLOTS];
   logic [ID_W-1:0] sdur_ff [SLOTS];
   logic [TAG_W-1:0] stag_ff [SLOTS];
   logic [CW-1:0] n_ff, n_in;
   logic ov_ff, ov_in, ol_ff, ol_in;
   kind_type ok_ff, ok_in;
   logic [ID_W-1:0] oid_ff, oid_in;
   logic [TAG_W-1:0] otag_ff, otag_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [SW-1:0] best_ff, best_in;
   logic best_ok_ff, best_ok_in;
   logic [SLOTS-1:0] match, hit_nid;
   logic [ID_W-1:0] nid;
   logic wr_en;
   logic [SW-1:0] wr_slot, free_slot, hit_slot;
   logic any_free, any_hit, out_free;

   assign out_free = !ov_ff || out_ready;
   assign cmd_ready = (st_ff == ST_IDLE) && out_free;
   assign nid = idc_ff + 32'd1;

   always_comb begin
      any_free = 1'b0;
      free_slot = '0;
      any_hit = 1'b0;
      hit_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (sid_ff[i] == cmd.target_id);
         hit_nid[i] = valid_ff[i] && (sid_ff[i] == nid);
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_slot = SW'(i);
         end
         if (hit_nid[i]) begin
            any_hit = 1'b1;
            hit_slot = SW'(i);
         end
      end
   end

   always_comb begin
      st_in = st_ff;
      time_in = time_ff;
      idc_in = idc_ff;
      valid_in = valid_ff;
      due_in = due_ff;
      n_in = n_ff;
      ov_in = ov_ff && !out_ready;
      ok_in = ok_ff;
      oid_in = oid_ff;
      otag_in = otag_ff;
      ol_in = ol_ff;
      scan_in = scan_ff;
      best_in = best_ff;
      best_ok_in = best_ok_ff;
      wr_en = 1'b0;
      wr_slot = any_hit ? hit_slot : free_slot;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               unique case (cmd.op)
                  OP_START: begin
                     ov_in = 1'b1;
                     ol_in = 1'b1;
                     otag_in = cmd.tag;
                     if (any_hit || any_free) begin
                        wr_en = 1'b1;
                        idc_in = nid;
                        valid_in[wr_slot] = 1'b1;
                        ok_in = KIND_ID;
                        oid_in = nid;
                     end else begin
                        ok_in = KIND_REJECTED;
                        oid_in = '0;
                     end
                  end
                  OP_STOP: valid_in = valid_ff & ~match;
                  OP_TICK: begin
                     time_in = time_ff + 32'd1;
                     for (int i = 0; i < SLOTS; i++)
                        due_in[i] = valid_ff[i] &&
                           ((time_in - sst_ff[i]) >= sdur_ff[i]);
                     n_in = '0;
                     scan_in = '0;
                     best_ok_in = 1'b0;
                     st_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (due_ff[scan_ff] &&
                  (!best_ok_ff || sid_ff[scan_ff] < sid_ff[best_ff])) begin
               best_in = scan_ff;
               best_ok_in = 1'b1;
            end
            scan_in = scan_ff + SW'(1);
            if (scan_ff == SW'(SLOTS - 1)) st_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!best_ok_ff) begin
               st_in = ST_IDLE;
            end else if (out_free) begin
               ov_in = 1'b1;
               ok_in = KIND_EXPIRED;
               oid_in = sid_ff[best_ff];
               otag_in = stag_ff[best_ff];
               due_in[best_ff] = 1'b0;
               valid_in[best_ff] = 1'b0;
               n_in = n_ff + CW'(1);
               ol_in = (n_in == CW'(MAX_RESULTS)) || ((due_in & valid_in) == '0);
               scan_in = '0;
               best_ok_in = 1'b0;
               st_in = ol_in ? ST_IDLE : ST_SCAN;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sid_ff[wr_slot] <= nid;
         sst_ff[wr_slot] <= time_ff;
         sdur_ff[wr_slot] <= cmd.duration;
         stag_ff[wr_slot] <= cmd.tag;
      end
      due_ff <= due_in;
      n_ff <= n_in;
      ok_ff <= ok_in;
      oid_ff <= oid_in;
      otag_ff <= otag_in;
      ol_ff <= ol_in;
      scan_ff <= scan_in;
      best_ff <= best_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         time_ff <= '0;
         idc_ff <= '0;
         valid_ff <= '0;
         ov_ff <= 1'b0;
         best_ok_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         time_ff <= time_in;
         idc_ff <= idc_in;
         valid_ff <= valid_in;
         ov_ff <= ov_in;
         best_ok_ff <= best_ok_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_kind = ok_ff;
   assign out_id = oid_ff;
   assign out_tag = otag_ff;
   assign out_last = ol_ff;
endmodule

### bench/tb_one_shot_timer_table_top.sv
// Testbench for the one-shot timer table: drives start, stop and tick items,
// predicts the id, expiry and rejection results and checks them in order.
// Depends on ostt_pkg and one_shot_timer_table_top.
`timescale 1ns / 1ps
module tb_one_shot_timer_table_top;
   import ostt_pkg::*;

   localparam int NSLOT = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      kind_type kind;
      logic [31:0] id;
      logic [15:0] tag;
      logic last;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0] req_tuser = OP_NONE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   one_shot_timer_table_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // timer table shadow
   logic [31:0] now_ticks, last_id;
   logic live[NSLOT];
   logic [31:0] live_id[NSLOT], live_start[NSLOT], live_dur[NSLOT];
   logic [15:0] live_tag[NSLOT];
   outcome_type pending_results[$];

   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int expiries_seen = 0;
   int rejects_seen = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   function automatic void push_result(kind_type k, logic [31:0] id, logic [15:0] tag,
                                       logic last);
      outcome_type o;
      o.kind = k; o.id = id; o.tag = tag; o.last = last;
      pending_results.push_back(o);
   endfunction

   function automatic void predict_table(op_type op, logic [31:0] dur, logic [31:0] tid,
                                         logic [15:0] tag);
      int slot;
      int best;
      int n;
      logic [31:0] nid;
      logic due[NSLOT];
      slot = -1;
      case (op)
         OP_START: begin
            nid = last_id + 1;
            for (int i = 0; i < NSLOT; i++)
               if (slot < 0 && live[i] && live_id[i] == nid) slot = i;
            for (int i = 0; i < NSLOT; i++)
               if (slot < 0 && !live[i]) slot = i;
            if (slot < 0) begin
               push_result(KIND_REJECTED, '0, tag, 1'b1);
            end else begin
               last_id = nid;
               live[slot] = 1'b1;
               live_id[slot] = nid;
               live_start[slot] = now_ticks;
               live_dur[slot] = dur;
               live_tag[slot] = tag;
               push_result(KIND_ID, nid, tag, 1'b1);
            end
         end
         OP_STOP: begin
            for (int i = 0; i < NSLOT; i++)
               if (live[i] && live_id[i] == tid) live[i] = 1'b0;
         end
         OP_TICK: begin
            now_ticks = now_ticks + 1;
            for (int i = 0; i < NSLOT; i++)
               due[i] = live[i] && (now_ticks - live_start[i] >= live_dur[i]);
            n = 0;
            while (n < MAX_RESULTS) begin
               best = -1;
               for (int i = 0; i < NSLOT; i++)
                  if (due[i] && (best < 0 || live_id[i] < live_id[best])) best = i;
               if (best < 0) break;
               due[best] = 1'b0;
               live[best] = 1'b0;
               push_result(KIND_EXPIRED, live_id[best], live_tag[best], 1'b0);
               n++;
            end
            if (n > 0) pending_results[$].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(op_type op, logic [31:0] dur, logic [31:0] tid,
                            logic [15:0] tag);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {tag, tid, dur};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_table(op, dur, tid, tag);
      items_sent++;
   endtask

   task automatic wait_drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && guard < WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // receiver: stall pattern of its own
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 15) < 11);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result kind=%0d id=%0h", rsp_tuser, rsp_tdata[31:0]);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (want.kind == KIND_EXPIRED) expiries_seen++;
            if (want.kind == KIND_REJECTED) rejects_seen++;
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d actual %0d", want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] !== want.id) begin
               $error("timer_id: expected %0h actual %0h", want.id, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[47:32] !== want.tag) begin
               $error("tag_out: expected %0h actual %0h", want.tag, rsp_tdata[47:32]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b actual %0b", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted item on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_start_stop_basic();
      send_item(OP_START, 32'd0, 32'd0, 16'h0000);
      send_item(OP_START, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
      send_item(OP_START, 32'd3, 32'd0, 16'hA5A5);
      send_item(OP_STOP, 32'd0, 32'd2, 16'h0);
      send_item(OP_STOP, 32'd0, 32'hFFFF_FFFF, 16'h0);
      send_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_TICK, 32'd0, 32'd0, 16'h0);
      send_item(OP_TICK, 32'd0, 32'd0, 16'h0);
      send_item(OP_TICK, 32'd0, 32'd0, 16'h0);
      send_item(OP_TICK, 32'd0, 32'd0, 16'h0);
      send_item(OP_STOP, 32'd0, 32'd0, 16'h0);
   endtask

   task automatic test_full_table();
      // fill, overflow, then expire many at once
      for (int i = 0; i < NSLOT + 1; i++)
         send_item(OP_START, (i < 15) ? 32'd1 : 32'd2, 32'd0, 16'(i * 16'h1111));
      send_item(OP_TICK, 32'd0, 32'd0, 16'h0);
      send_item(OP_TICK, 32'd0, 32'd0, 16'h0);
      send_item(OP_TICK, 32'd0, 32'd0, 16'h0);
      wait_drain();
   endtask

   task automatic test_random_mix();
      int live_cnt;
      logic [31:0] tid;
      for (int n = 0; n < 280; n++) begin
         live_cnt = 0;
         for (int i = 0; i < NSLOT; i++) if (live[i]) live_cnt++;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:
               send_item(OP_START,
                         ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12),
                         $urandom, 16'($urandom));
            8, 9, 10: begin
               tid = ($urandom_range(0, 3) == 0) ? $urandom : last_id - $urandom_range(0, 8);
               send_item(OP_STOP, $urandom, tid, 16'($urandom));
            end
            19: send_item(OP_NONE, $urandom, $urandom, 16'($urandom));
            default: send_item(OP_TICK, $urandom, $urandom, 16'($urandom));
         endcase
      end
      wait_drain();
   endtask

   initial begin
      now_ticks = '0;
      last_id = '0;
      for (int i = 0; i < NSLOT; i++) live[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_start_stop_basic();
      test_full_table();
      test_random_mix();
      repeat (200) @(posedge clock);
      $display("Sent %0d items; checked %0d results (%0d expiries, %0d rejections).",
               items_sent, results_seen, expiries_seen, rejects_seen);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (pending_results.size() != 0)
            $error("%0d expected results never arrived", pending_results.size());
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
